[src/cau_pkg.sv]
package cau_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int RB = 30;
  localparam int PW = 2 * DW;

  // Ratio divider: small * 2^(RB+1) / large, quotient at most 2^(DW-1).
  localparam int RN_W = DW + RB + 1;
  localparam int RQ_W = DW;
  // Main dividers: numerator magnitude * 2^(FB+1) / denominator magnitude.
  localparam int MD_W = PW - 1;
  localparam int MN_W = MD_W + FB + 1;
  localparam int MQ_W = PW + FB - RB;

  localparam int SAT_MW = 64;

  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_SUB  = 3'd1,
    FUNC_MUL  = 3'd2,
    FUNC_DIV  = 3'd3,
    FUNC_CONJ = 3'd4,
    FUNC_NEG  = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]           func;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 overflow;
    logic                 div_zero;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ovf;
  } sat_t;

  // Clamps a sign and magnitude to the signed DW-bit range.
  function automatic sat_t sat_mag(input logic neg, input logic [SAT_MW-1:0] mag);
    logic [SAT_MW-1:0] lim;
    logic [SAT_MW-1:0] m;
    sat_t              s;
    lim = neg ? (SAT_MW'(1) << (DW - 1)) : ((SAT_MW'(1) << (DW - 1)) - SAT_MW'(1));
    s.ovf = (mag > lim);
    m = s.ovf ? lim : mag;
    s.val = neg ? (DW'(0) - m[DW-1:0]) : m[DW-1:0];
    return s;
  endfunction

endpackage

[src/complex_arith_unit.sv]
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  cau_pkg::in_t  (func, a_re, a_im, b_re, b_im)
// out_     output     out_valid/ out_stall cau_pkg::out_t (res_re, res_im, overflow, div_zero)
//
// One item enters per cycle while in_stall is low; the pipeline holds the 32-stage ratio
// divider and the 50-stage quotient dividers among its stages.
// Reset is synchronous on rst_n and clears only the valid bits of the stages.
// The whole pipeline advances together; it holds only while the output register
// has an item and out_stall is high, and then in_stall is high as well.
module complex_arith_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);
  import cau_pkg::*;

  typedef struct packed {
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          ovf;
  } early_t;

  typedef struct packed {
    early_t               early;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] d;
    logic                 cmp;
    logic                 is_div;
    logic                 dz;
  } rside_t;

  typedef struct packed {
    early_t early;
    logic   is_div;
    logic   dz;
    logic   neg_re;
  } dside_t;

  localparam int RS_W = $bits(rside_t);
  localparam int DS_W = $bits(dside_t);
  localparam logic signed [PW+1:0] HALF = (PW + 2)'(1) << (FB - 1);

  logic out_valid_r;
  logic en;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 0: input register.
  logic s0_v_r;
  in_t  s0_d_r;

  // Stage 1: products, simple sums, divisor magnitudes.
  logic                 s1_v_r;
  logic [2:0]           s1_func_r;
  logic signed [DW-1:0] s1_a_r, s1_ai_r, s1_c_r, s1_d_r;
  logic signed [DW:0]   s1_re_r, s1_im_r;
  logic signed [PW-1:0] s1_pac_r, s1_pbd_r, s1_pbc_r, s1_pad_r;
  logic [DW-1:0]        s1_cm_r, s1_dm_r;

  logic signed [DW:0] a33, ai33, c33, d33, cneg, dneg;
  logic signed [DW:0] re_nxt, im_nxt;

  assign a33  = {s0_d_r.a_re[DW-1], s0_d_r.a_re};
  assign ai33 = {s0_d_r.a_im[DW-1], s0_d_r.a_im};
  assign c33  = {s0_d_r.b_re[DW-1], s0_d_r.b_re};
  assign d33  = {s0_d_r.b_im[DW-1], s0_d_r.b_im};
  assign cneg = -c33;
  assign dneg = -d33;

  always_comb begin
    case (func_t'(s0_d_r.func))
      FUNC_ADD: begin
        re_nxt = a33 + c33;
        im_nxt = ai33 + d33;
      end
      FUNC_SUB: begin
        re_nxt = a33 - c33;
        im_nxt = ai33 - d33;
      end
      FUNC_CONJ: begin
        re_nxt = a33;
        im_nxt = -ai33;
      end
      FUNC_NEG: begin
        re_nxt = -a33;
        im_nxt = -ai33;
      end
      default: begin
        re_nxt = '0;
        im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func_r <= s0_d_r.func;
      s1_a_r    <= s0_d_r.a_re;
      s1_ai_r   <= s0_d_r.a_im;
      s1_c_r    <= s0_d_r.b_re;
      s1_d_r    <= s0_d_r.b_im;
      s1_re_r   <= re_nxt;
      s1_im_r   <= im_nxt;
      s1_pac_r  <= $signed(s0_d_r.a_re) * $signed(s0_d_r.b_re);
      s1_pbd_r  <= $signed(s0_d_r.a_im) * $signed(s0_d_r.b_im);
      s1_pbc_r  <= $signed(s0_d_r.a_im) * $signed(s0_d_r.b_re);
      s1_pad_r  <= $signed(s0_d_r.a_re) * $signed(s0_d_r.b_im);
      s1_cm_r   <= c33[DW] ? cneg[DW-1:0] : c33[DW-1:0];
      s1_dm_r   <= d33[DW] ? dneg[DW-1:0] : d33[DW-1:0];
    end
  end

  // Stage 2: product sums, saturation of the exact results, Smith branch.
  logic                 s2_v_r;
  logic [2:0]           s2_func_r;
  logic signed [DW-1:0] s2_a_r, s2_ai_r, s2_c_r, s2_d_r;
  logic signed [PW:0]   s2_pre_r, s2_pim_r;
  early_t               s2_early_r;
  logic [DW-1:0]        s2_small_r, s2_large_r;
  logic                 s2_cmp_r, s2_dz_r;

  logic [DW:0] re_abs, im_abs;
  sat_t        sre_simple, sim_simple;
  logic        cmp_nxt;

  assign re_abs     = s1_re_r[DW] ? -s1_re_r : s1_re_r;
  assign im_abs     = s1_im_r[DW] ? -s1_im_r : s1_im_r;
  assign sre_simple = sat_mag(s1_re_r[DW], SAT_MW'(re_abs));
  assign sim_simple = sat_mag(s1_im_r[DW], SAT_MW'(im_abs));
  assign cmp_nxt    = (s1_cm_r >= s1_dm_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_func_r     <= s1_func_r;
      s2_a_r        <= s1_a_r;
      s2_ai_r       <= s1_ai_r;
      s2_c_r        <= s1_c_r;
      s2_d_r        <= s1_d_r;
      s2_pre_r      <= $signed({s1_pac_r[PW-1], s1_pac_r}) - $signed({s1_pbd_r[PW-1], s1_pbd_r});
      s2_pim_r      <= $signed({s1_pbc_r[PW-1], s1_pbc_r}) + $signed({s1_pad_r[PW-1], s1_pad_r});
      s2_early_r.re <= sre_simple.val;
      s2_early_r.im <= sim_simple.val;
      s2_early_r.ovf <= sre_simple.ovf | sim_simple.ovf;
      s2_small_r    <= cmp_nxt ? s1_dm_r : s1_cm_r;
      s2_large_r    <= cmp_nxt ? s1_cm_r : s1_dm_r;
      s2_cmp_r      <= cmp_nxt;
      s2_dz_r       <= (s1_cm_r == '0) && (s1_dm_r == '0);
    end
  end

  // Stage 3: product rounding, half away from zero.
  logic                 s3_v_r;
  logic [2:0]           s3_func_r;
  logic signed [DW-1:0] s3_a_r, s3_ai_r, s3_c_r, s3_d_r;
  logic [PW-FB:0]       s3_mre_r, s3_mim_r;
  logic                 s3_nre_r, s3_nim_r;
  early_t               s3_early_r;
  logic [DW-1:0]        s3_small_r, s3_large_r;
  logic                 s3_cmp_r, s3_dz_r;

  logic signed [PW+1:0] pre_x, pim_x, rnd_re, rnd_im;

  assign pre_x  = {s2_pre_r[PW], s2_pre_r};
  assign pim_x  = {s2_pim_r[PW], s2_pim_r};
  assign rnd_re = pre_x[PW+1] ? (HALF - pre_x) : (pre_x + HALF);
  assign rnd_im = pim_x[PW+1] ? (HALF - pim_x) : (pim_x + HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_func_r  <= s2_func_r;
      s3_a_r     <= s2_a_r;
      s3_ai_r    <= s2_ai_r;
      s3_c_r     <= s2_c_r;
      s3_d_r     <= s2_d_r;
      s3_mre_r   <= rnd_re[PW:FB];
      s3_mim_r   <= rnd_im[PW:FB];
      s3_nre_r   <= pre_x[PW+1];
      s3_nim_r   <= pim_x[PW+1];
      s3_early_r <= s2_early_r;
      s3_small_r <= s2_small_r;
      s3_large_r <= s2_large_r;
      s3_cmp_r   <= s2_cmp_r;
      s3_dz_r    <= s2_dz_r;
    end
  end

  // Stage 4: product saturation and choice of the non-division result.
  logic   s4_v_r;
  rside_t s4_side_r;
  logic [DW-1:0] s4_small_r, s4_large_r;

  sat_t sre_mul, sim_mul;
  logic is_mul, is_div;

  assign sre_mul = sat_mag(s3_nre_r, SAT_MW'(s3_mre_r));
  assign sim_mul = sat_mag(s3_nim_r, SAT_MW'(s3_mim_r));
  assign is_mul  = (s3_func_r == FUNC_MUL);
  assign is_div  = (s3_func_r == FUNC_DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r.early.re  <= is_mul ? sre_mul.val : s3_early_r.re;
      s4_side_r.early.im  <= is_mul ? sim_mul.val : s3_early_r.im;
      s4_side_r.early.ovf <= is_mul ? (sre_mul.ovf | sim_mul.ovf) : s3_early_r.ovf;
      s4_side_r.a         <= s3_a_r;
      s4_side_r.ai        <= s3_ai_r;
      s4_side_r.c         <= s3_c_r;
      s4_side_r.d         <= s3_d_r;
      s4_side_r.cmp       <= s3_cmp_r;
      s4_side_r.is_div    <= is_div;
      s4_side_r.dz        <= is_div & s3_dz_r;
      s4_small_r          <= s3_small_r;
      s4_large_r          <= s3_large_r;
    end
  end

  // Ratio of the smaller to the larger divisor part.
  logic              rdiv_v;
  logic [RQ_W-1:0]   rdiv_q;
  logic [RS_W-1:0]   rdiv_side;

  cau_div_pipe #(
    .N_W   (RN_W),
    .D_W   (DW),
    .Q_W   (RQ_W),
    .SIDE_W(RS_W)
  ) u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s4_v_r),
    .num      ({s4_small_r, {(RB + 1){1'b0}}}),
    .den      (s4_large_r),
    .side_in  (s4_side_r),
    .out_valid(rdiv_v),
    .quo      (rdiv_q),
    .side_out (rdiv_side)
  );

  // Stage 5: signed ratio.
  logic                 s5_v_r;
  rside_t               s5_side_r;
  logic signed [DW-1:0] s5_r_r;

  rside_t      rside;
  logic [DW:0] rsum;
  logic [DW-1:0] rmag;
  logic        rneg;

  assign rside = rside_t'(rdiv_side);
  assign rsum  = {1'b0, rdiv_q} + (DW + 1)'(1);
  assign rmag  = rsum[DW:1];
  assign rneg  = rside.c[DW-1] ^ rside.d[DW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= rside;
      s5_r_r    <= rneg ? -$signed(rmag) : $signed(rmag);
    end
  end

  // Stage 6: operand times ratio.
  logic                 s6_v_r;
  rside_t               s6_side_r;
  logic signed [PW-1:0] s6_p1_r, s6_p2_r, s6_p3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s5_side_r;
      s6_p1_r   <= s5_side_r.a * s5_r_r;
      s6_p2_r   <= s5_side_r.ai * s5_r_r;
      s6_p3_r   <= (s5_side_r.cmp ? s5_side_r.d : s5_side_r.c) * s5_r_r;
    end
  end

  // Stage 7: numerators and denominator.
  logic                 s7_v_r;
  early_t               s7_early_r;
  logic                 s7_is_div_r, s7_dz_r;
  logic signed [PW-1:0] s7_nre_r, s7_nim_r, s7_den_r;

  logic signed [PW-1:0] a_sh, ai_sh, c_sh, d_sh;

  assign a_sh  = {{(PW - DW - RB){s6_side_r.a[DW-1]}}, s6_side_r.a, {RB{1'b0}}};
  assign ai_sh = {{(PW - DW - RB){s6_side_r.ai[DW-1]}}, s6_side_r.ai, {RB{1'b0}}};
  assign c_sh  = {{(PW - DW - RB){s6_side_r.c[DW-1]}}, s6_side_r.c, {RB{1'b0}}};
  assign d_sh  = {{(PW - DW - RB){s6_side_r.d[DW-1]}}, s6_side_r.d, {RB{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      s7_early_r  <= s6_side_r.early;
      s7_is_div_r <= s6_side_r.is_div;
      s7_dz_r     <= s6_side_r.dz;
      if (s6_side_r.cmp) begin
        s7_nre_r <= a_sh + s6_p2_r;
        s7_nim_r <= ai_sh - s6_p1_r;
        s7_den_r <= c_sh + s6_p3_r;
      end else begin
        s7_nre_r <= s6_p1_r + ai_sh;
        s7_nim_r <= s6_p2_r - a_sh;
        s7_den_r <= s6_p3_r + d_sh;
      end
    end
  end

  // Stage 8: magnitudes and quotient signs.
  logic           s8_v_r;
  dside_t         s8_side_r;
  logic           s8_neg_im_r;
  logic [MD_W-1:0] s8_nre_m_r, s8_nim_m_r, s8_den_m_r;

  logic [PW-1:0] nre_abs, nim_abs, den_abs;

  assign nre_abs = s7_nre_r[PW-1] ? -s7_nre_r : s7_nre_r;
  assign nim_abs = s7_nim_r[PW-1] ? -s7_nim_r : s7_nim_r;
  assign den_abs = s7_den_r[PW-1] ? -s7_den_r : s7_den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side_r.early  <= s7_early_r;
      s8_side_r.is_div <= s7_is_div_r;
      s8_side_r.dz     <= s7_dz_r;
      s8_side_r.neg_re <= s7_nre_r[PW-1] ^ s7_den_r[PW-1];
      s8_neg_im_r      <= s7_nim_r[PW-1] ^ s7_den_r[PW-1];
      s8_nre_m_r       <= nre_abs[MD_W-1:0];
      s8_nim_m_r       <= nim_abs[MD_W-1:0];
      s8_den_m_r       <= den_abs[MD_W-1:0];
    end
  end

  logic            qre_v, qim_v;
  logic [MQ_W-1:0] qre, qim;
  logic [DS_W-1:0] qre_side;
  logic            qim_neg;

  cau_div_pipe #(
    .N_W   (MN_W),
    .D_W   (MD_W),
    .Q_W   (MQ_W),
    .SIDE_W(DS_W)
  ) u_re_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s8_v_r),
    .num      ({s8_nre_m_r, {(FB + 1){1'b0}}}),
    .den      (s8_den_m_r),
    .side_in  (s8_side_r),
    .out_valid(qre_v),
    .quo      (qre),
    .side_out (qre_side)
  );

  cau_div_pipe #(
    .N_W   (MN_W),
    .D_W   (MD_W),
    .Q_W   (MQ_W),
    .SIDE_W(1)
  ) u_im_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s8_v_r),
    .num      ({s8_nim_m_r, {(FB + 1){1'b0}}}),
    .den      (s8_den_m_r),
    .side_in  (s8_neg_im_r),
    .out_valid(qim_v),
    .quo      (qim),
    .side_out (qim_neg)
  );

  // Stage 9: quotient rounding.
  logic          s9_v_r;
  dside_t        s9_side_r;
  logic          s9_neg_im_r;
  logic [MQ_W-1:0] s9_mre_r, s9_mim_r;

  logic [MQ_W:0] qre_sum, qim_sum;

  assign qre_sum = {1'b0, qre} + (MQ_W + 1)'(1);
  assign qim_sum = {1'b0, qim} + (MQ_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_side_r   <= dside_t'(qre_side);
      s9_neg_im_r <= qim_neg;
      s9_mre_r    <= qre_sum[MQ_W:1];
      s9_mim_r    <= qim_sum[MQ_W:1];
    end
  end

  // Output register: quotient saturation and final selection.
  out_t out_d_r;

  sat_t sre_div, sim_div;
  logic use_div;

  assign sre_div = sat_mag(s9_side_r.neg_re, SAT_MW'(s9_mre_r));
  assign sim_div = sat_mag(s9_neg_im_r, SAT_MW'(s9_mim_r));
  assign use_div = s9_side_r.is_div & !s9_side_r.dz;

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r.res_re   <= use_div ? sre_div.val : s9_side_r.early.re;
      out_d_r.res_im   <= use_div ? sim_div.val : s9_side_r.early.im;
      out_d_r.overflow <= use_div ? (sre_div.ovf | sim_div.ovf) : s9_side_r.early.ovf;
      out_d_r.div_zero <= s9_side_r.dz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      s9_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_v_r      <= in_valid;
      s1_v_r      <= s0_v_r;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= rdiv_v;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= s6_v_r;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= qre_v;
      out_valid_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_d_r;

`ifndef SYNTHESIS
  // The two quotient dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    qre_v == qim_v)
    else $error("quotient dividers out of step");

  a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_d_r.div_zero |->
      out_d_r.res_re == '0 && out_d_r.res_im == '0 && !out_d_r.overflow)
    else $error("zero divisor gave a nonzero result");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_d_r.overflow |->
      (out_d_r.res_re == {1'b0, {(DW - 1){1'b1}}}) || (out_d_r.res_re == {1'b1, {(DW - 1){1'b0}}}) ||
      (out_d_r.res_im == {1'b0, {(DW - 1){1'b1}}}) || (out_d_r.res_im == {1'b1, {(DW - 1){1'b0}}}))
    else $error("overflow flagged without a saturated part");

  // An item held at the output stays there while the stall lasts.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_d_r))
    else $error("stalled item lost");
`endif

endmodule

[src/cau_div_pipe.sv]
module cau_div_pipe #(
  parameter int N_W    = 63,
  parameter int D_W    = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    num,
  input  logic [D_W-1:0]    den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  // The quotient must fit in Q_W bits, so the bits of num above Q_W start
  // out smaller than den. Each stage shifts in one numerator bit and
  // retires one quotient bit into the same shift word.
  logic              v_r    [Q_W];
  logic [D_W-1:0]    rem_r  [Q_W];
  logic [D_W-1:0]    den_r  [Q_W];
  logic [Q_W-1:0]    lq_r   [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              pv;
    logic [D_W-1:0]    prem;
    logic [D_W-1:0]    pden;
    logic [Q_W-1:0]    plq;
    logic [SIDE_W-1:0] pside;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              take;

    if (k == 0) begin : g_src
      assign pv    = in_valid;
      assign prem  = D_W'(num[N_W-1:Q_W]);
      assign pden  = den;
      assign plq   = num[Q_W-1:0];
      assign pside = side_in;
    end else begin : g_src
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign pden  = den_r[k-1];
      assign plq   = lq_r[k-1];
      assign pside = side_r[k-1];
    end

    assign trial = {prem, plq[Q_W-1]};
    assign diff  = trial - {1'b0, pden};
    assign take  = (trial >= {1'b0, pden});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? diff[D_W-1:0] : trial[D_W-1:0];
        den_r[k]  <= pden;
        lq_r[k]   <= {plq[Q_W-2:0], take};
        side_r[k] <= pside;
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign quo       = lq_r[Q_W-1];
  assign side_out  = side_r[Q_W-1];

endmodule

[bench/complex_arith_unit_checker.sv]
`timescale 1ns / 100ps

module complex_arith_unit_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  cau_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  cau_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import cau_pkg::*;

  typedef struct {
    logic [63:0] m;
    logic        n;
  } mag_t;

  out_t expected_q[$];
  int   fails = 0;

  function automatic mag_t mk(logic [63:0] m, logic n);
    mag_t r;
    r.m = m;
    r.n = (m == 0) ? 1'b0 : n;
    return r;
  endfunction

  function automatic mag_t from_field(logic signed [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return mk(v[31] ? (64'd0 - e) : e, v[31]);
  endfunction

  function automatic mag_t m_add(mag_t a, mag_t b);
    if (a.n == b.n) return mk(a.m + b.m, a.n);
    if (a.m >= b.m) return mk(a.m - b.m, a.n);
    return mk(b.m - a.m, b.n);
  endfunction

  function automatic mag_t m_neg(mag_t a);
    return mk(a.m, ~a.n);
  endfunction

  function automatic mag_t m_mul(mag_t a, mag_t b);
    return mk(a.m * b.m, a.n ^ b.n);
  endfunction

  // Rounded n * 2^sh / d, half away from zero, as a bit-serial long division.
  function automatic logic [63:0] div_round(logic [63:0] n, int sh, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = 0;
    q = 0;
    if (d == 0) return 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    for (int k = 0; k <= sh; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic logic [31:0] clamp(mag_t a, ref logic ovf);
    logic [63:0] lim;
    logic [63:0] m;
    lim = (64'd1 << 31) - (a.n ? 64'd0 : 64'd1);
    m = a.m;
    if (m > lim) begin
      m = lim;
      ovf = 1'b1;
    end
    return a.n ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic out_t complex_result(in_t x);
    mag_t a, ai, c, d, re, im, r, nre, nim, den;
    logic ovf;
    out_t o;
    a = from_field(x.a_re);
    ai = from_field(x.a_im);
    c = from_field(x.b_re);
    d = from_field(x.b_im);
    re = mk(0, 0);
    im = mk(0, 0);
    ovf = 1'b0;
    o.div_zero = 1'b0;
    case (x.func)
      FUNC_ADD: begin
        re = m_add(a, c);
        im = m_add(ai, d);
      end
      FUNC_SUB: begin
        re = m_add(a, m_neg(c));
        im = m_add(ai, m_neg(d));
      end
      FUNC_MUL: begin
        re = m_add(m_mul(a, c), m_neg(m_mul(ai, d)));
        im = m_add(m_mul(ai, c), m_mul(a, d));
        re = mk((re.m + (64'd1 << (FB - 1))) >> FB, re.n);
        im = mk((im.m + (64'd1 << (FB - 1))) >> FB, im.n);
      end
      FUNC_DIV: begin
        if (c.m == 0 && d.m == 0) begin
          o.div_zero = 1'b1;
        end else begin
          if (c.m >= d.m) begin
            r = mk(div_round(d.m, RB, c.m), d.n ^ c.n);
            nre = m_add(mk(a.m << RB, a.n), m_mul(ai, r));
            nim = m_add(mk(ai.m << RB, ai.n), m_neg(m_mul(a, r)));
            den = m_add(mk(c.m << RB, c.n), m_mul(d, r));
          end else begin
            r = mk(div_round(c.m, RB, d.m), c.n ^ d.n);
            nre = m_add(m_mul(a, r), mk(ai.m << RB, ai.n));
            nim = m_add(m_mul(ai, r), m_neg(mk(a.m << RB, a.n)));
            den = m_add(m_mul(c, r), mk(d.m << RB, d.n));
          end
          re = mk(div_round(nre.m, FB, den.m), nre.n ^ den.n);
          im = mk(div_round(nim.m, FB, den.m), nim.n ^ den.n);
        end
      end
      FUNC_CONJ: begin
        re = a;
        im = m_neg(ai);
      end
      FUNC_NEG: begin
        re = m_neg(a);
        im = m_neg(ai);
      end
      default: ;
    endcase
    o.res_re = clamp(re, ovf);
    o.res_im = clamp(im, ovf);
    o.overflow = ovf;
    return o;
  endfunction

  assign pending    = expected_q.size();
  assign fail_count = fails;

  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && !in_stall) expected_q.push_back(complex_result(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.res_re !== want.res_re) begin
          $error("res_re expected %h actual %h", want.res_re, out_data.res_re);
          fails++;
        end
        if (out_data.res_im !== want.res_im) begin
          $error("res_im expected %h actual %h", want.res_im, out_data.res_im);
          fails++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow expected %b actual %b", want.overflow, out_data.overflow);
          fails++;
        end
        if (out_data.div_zero !== want.div_zero) begin
          $error("div_zero expected %b actual %b", want.div_zero, out_data.div_zero);
          fails++;
        end
      end
    end
  end
endmodule

[bench/complex_arith_unit_tb.sv]
`timescale 1ns / 100ps

module complex_arith_unit_tb;
  import cau_pkg::*;

  localparam int LATENCY = 94;
  localparam int CYCLE_LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;
  int    fail_count;
  int    pending;
  int    cycles = 0;
  logic  calm = 1'b0;

  always #4 clk = ~clk;

  complex_arith_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  complex_arith_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 36);

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'(signed'($urandom_range(8)) - 4) << 16;
      4: return 32'(signed'($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [2:0] f, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    in_data <= '{func: f, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 36);
    end
  endtask

  initial begin
    logic [2:0] f;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Extremes, every operation, zero divisor, unused codes.
    for (int k = 0; k < 8; k++) begin
      send_item(3'(k), 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(3'(k), 32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0);
    end
    send_item(FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0001, 32'hFFFF_0000);
    send_item(FUNC_DIV, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_item(FUNC_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(FUNC_NEG, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int n = 0; n < 1850; n++) begin
      calm = (n >= 600 && n < 900);
      idle_gap();
      f = ($urandom_range(19) == 0) ? 3'(6 + $urandom_range(1)) : 3'($urandom_range(5));
      send_item(f, pick_value(), pick_value(), pick_value(), pick_value());
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[filelist.f]
src/cau_pkg.sv
src/cau_div_pipe.sv
src/complex_arith_unit.sv
bench/complex_arith_unit_checker.sv
bench/complex_arith_unit_tb.sv
